FILE: hw/rtl/slotted_page_space_manager_core_macros.svh
// Assertion macros for the slotted page space manager.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef SLOTTED_PAGE_SPACE_MANAGER_CORE_MACROS_SVH
`define SLOTTED_PAGE_SPACE_MANAGER_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spm: same-cycle check failed");
// next-cycle implication
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spm: next-cycle check failed");
`else
`define SPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/spm_pkg.sv
`default_nettype none
package spm_pkg;

	// default geometry
	localparam int DEF_PAGE_BYTES   = 4096;
	localparam int DEF_MAX_SLOTS    = 1024;
	localparam int DEF_HEADER_BYTES = 4;
	localparam int DEF_SLOT_BYTES   = 4;

	// port field widths
	localparam int FUNC_W    = 3;
	localparam int SLOT_IN_W = 10;
	localparam int LEN_IN_W  = 13;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 11;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_FORMAT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

	// shared adder operations
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	// deleted-slot bitmap word geometry
	localparam int BM_W  = 32;
	localparam int BIT_W = 5;

	// bitmap control from the sequencer
	typedef struct packed {
		logic rd_en;
		logic rd_low;
		logic wr_en;
		logic clr_all;
	} fm_ctrl_t;

	// index of the lowest set bit of a bitmap word (zero if none)
	function automatic logic [BIT_W-1:0] lowest_bit(input logic [BM_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = BM_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/slotted_page_space_manager_core.sv
// Channel  | Handshake            | Fields
// ---------+----------------------+-----------------------------------------------
// request  | in_valid / in_stall  | func, slot_index, record_length
// result   | out_valid / out_stall| status, slot_out, rec_offset,
//          |                      | record_length_out, slot_count, free_gap
//
// Format, look up, delete and in-place update pass through the fetch, decode and
// gap steps before out_valid rises. Insert and a relocating update go on from
// decode through find, scan, check and place to gap; page full is seen early,
// after scan with no slot left or after check with too small a gap.
// The single add/subtract unit and the registered reads of the directory and
// bitmap memories set these steps.
// Reset leaves the page formatted (no slots, record area at the page end); no
// clearing pass is needed. in_stall is high while a request is in work; a stalled
// result holds its register and the next request can still be taken meanwhile,
// the stall then holding that request in its last step until the result is taken.
`default_nettype none
`include "slotted_page_space_manager_core_macros.svh"
module slotted_page_space_manager_core
	import spm_pkg::*;
#(
	parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
	parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int SLOT_BYTES   = DEF_SLOT_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [FUNC_W-1:0]    func,
	input  logic [SLOT_IN_W-1:0] slot_index,
	input  logic [LEN_IN_W-1:0]  record_length,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_IN_W-1:0] slot_out,
	output logic [LEN_IN_W-1:0]  rec_offset,
	output logic [LEN_IN_W-1:0]  record_length_out,
	output logic [COUNT_W-1:0]   slot_count,
	output logic [LEN_IN_W-1:0]  free_gap
);

	localparam int OFF_W  = $clog2(PAGE_BYTES + 1);
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int DE_MAX = HEADER_BYTES + MAX_SLOTS * SLOT_BYTES;
	localparam int DE_W   = $clog2(DE_MAX + 1);
	localparam int W1     = (OFF_W > DE_W) ? OFF_W : DE_W;
	localparam int W2     = (W1 > LEN_IN_W) ? W1 : LEN_IN_W;
	localparam int AW     = W2 + 1;
	localparam int CMP_W  = (CNT_W > SLOT_IN_W) ? CNT_W : SLOT_IN_W;
	localparam int NW     = (MAX_SLOTS + BM_W - 1) / BM_W;
	localparam int WI_W   = (NW > 1) ? $clog2(NW) : 1;
	localparam int ENT_W  = 1 + 2 * OFF_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FETCH  = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_FIND   = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_CHECK  = 3'd5;
	localparam logic [2:0] ST_PLACE  = 3'd6;
	localparam logic [2:0] ST_GAP    = 3'd7;

	logic [2:0]           state_q;
	logic [FUNC_W-1:0]    func_q;
	logic [SLOT_IN_W-1:0] slot_q;
	logic [LEN_IN_W-1:0]  len_q;
	logic [CNT_W-1:0]     used_q;
	logic [DE_W-1:0]      dir_end_q;
	logic [OFF_W-1:0]     ras_q;
	logic [AW-1:0]        acc_q;
	logic                 found_q;
	logic [BIT_W-1:0]     bit_q;
	logic [SLOT_W-1:0]    reuse_q;

	logic [STATUS_W-1:0]  res_status_q;
	logic [SLOT_IN_W-1:0] res_slot_q;
	logic [OFF_W-1:0]     res_off_q;
	logic [OFF_W-1:0]     res_len_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [SLOT_IN_W-1:0] slot_out_q;
	logic [LEN_IN_W-1:0]  rec_offset_q;
	logic [LEN_IN_W-1:0]  record_length_out_q;
	logic [COUNT_W-1:0]   slot_count_q;
	logic [LEN_IN_W-1:0]  free_gap_q;

	logic                 in_fire;
	logic                 out_free;

	logic                 alu_op;
	logic [AW-1:0]        alu_a;
	logic [AW-1:0]        alu_b;
	logic [AW-1:0]        alu_y;
	logic                 alu_borrow;

	logic [ENT_W-1:0]     dir_rd;
	logic                 dir_we;
	logic [SLOT_W-1:0]    dir_wa;
	logic [ENT_W-1:0]     dir_wd;

	fm_ctrl_t             fm_ctrl;
	logic [WI_W-1:0]      fm_wr_word;
	logic [BM_W-1:0]      fm_wr_data;
	logic [BM_W-1:0]      fm_eff;
	logic [WI_W-1:0]      fm_word;
	logic                 fm_any;

	logic                 in_range;
	logic                 ent_valid;
	logic [OFF_W-1:0]     ent_off;
	logic [OFF_W-1:0]     ent_len;
	logic                 fits;
	logic                 upd_inplace;
	logic                 del_req;
	logic [WI_W-1:0]      slot_word;
	logic [BM_W-1:0]      slot_mask;
	logic [BM_W-1:0]      reuse_mask;
	logic [DE_W-1:0]      dir_end_inc;
	logic                 no_new_slot;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// decode helpers
	assign in_range    = CMP_W'(slot_q) < CMP_W'(used_q);
	assign ent_valid   = dir_rd[ENT_W-1];
	assign ent_off     = dir_rd[ENT_W-2 -: OFF_W];
	assign ent_len     = dir_rd[OFF_W-1:0];
	assign fits        = !alu_borrow;
	assign upd_inplace = (func_q == FUNC_UPDATE) && in_range && ent_valid && fits;
	assign del_req     = in_range && ((func_q == FUNC_DELETE) ||
		((func_q == FUNC_UPDATE) && !(ent_valid && fits)));
	assign slot_word   = WI_W'(slot_q >> BIT_W);
	assign slot_mask   = {{(BM_W-1){1'b0}}, 1'b1} << slot_q[BIT_W-1:0];
	assign reuse_mask  = {{(BM_W-1){1'b0}}, 1'b1} << bit_q;
	assign dir_end_inc = DE_W'(dir_end_q + SLOT_BYTES);
	assign no_new_slot = !fm_any && (used_q == CNT_W'(MAX_SLOTS));

	// operand selection and memory writes per step
	always_comb begin
		alu_op          = ALU_SUB;
		alu_a           = AW'(ras_q);
		alu_b           = AW'(dir_end_q);
		dir_we          = 1'b0;
		dir_wa          = SLOT_W'(slot_q);
		dir_wd          = {1'b0, ent_off, {OFF_W{1'b0}}};
		fm_ctrl.rd_en   = 1'b0;
		fm_ctrl.rd_low  = 1'b0;
		fm_ctrl.wr_en   = 1'b0;
		fm_ctrl.clr_all = 1'b0;
		fm_wr_word      = slot_word;
		fm_wr_data      = fm_eff | slot_mask;
		case (state_q)
			ST_FETCH: begin
				fm_ctrl.rd_en = 1'b1;
			end
			ST_DECODE: begin
				// stored length against requested length
				alu_a           = AW'(ent_len);
				alu_b           = AW'(len_q);
				dir_we          = del_req || upd_inplace;
				if (upd_inplace) begin
					dir_wd = {1'b1, ent_off, OFF_W'(len_q)};
				end
				fm_ctrl.wr_en   = del_req;
				fm_ctrl.clr_all = (func_q == FUNC_FORMAT);
			end
			ST_FIND: begin
				fm_ctrl.rd_en  = 1'b1;
				fm_ctrl.rd_low = 1'b1;
			end
			ST_SCAN: begin
				// bytes needed: directory end (plus a new entry) plus record
				alu_op = ALU_ADD;
				alu_a  = fm_any ? AW'(dir_end_q) : AW'(dir_end_inc);
				alu_b  = AW'(len_q);
			end
			ST_CHECK: begin
				alu_b = acc_q;
			end
			ST_PLACE: begin
				alu_b         = AW'(len_q);
				dir_we        = 1'b1;
				dir_wa        = found_q ? reuse_q : SLOT_W'(used_q);
				dir_wd        = {1'b1, alu_y[OFF_W-1:0], OFF_W'(len_q)};
				fm_ctrl.wr_en = found_q;
				fm_wr_word    = fm_word;
				fm_wr_data    = fm_eff & ~reuse_mask;
			end
			default: begin
			end
		endcase
	end

	spm_alu #(
		.AW(AW)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.y     (alu_y),
		.borrow(alu_borrow)
	);

	spm_dir_ram #(
		.DEPTH(MAX_SLOTS),
		.AW   (SLOT_W),
		.DW   (ENT_W)
	) u_dir_ram (
		.clk    (clk),
		.rd_en  (state_q == ST_FETCH),
		.rd_addr(SLOT_W'(slot_q)),
		.rd_data(dir_rd),
		.wr_en  (dir_we),
		.wr_addr(dir_wa),
		.wr_data(dir_wd)
	);

	spm_free_map #(
		.NW  (NW),
		.WI_W(WI_W)
	) u_free_map (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fm_ctrl),
		.rd_word(slot_word),
		.wr_word(fm_wr_word),
		.wr_data(fm_wr_data),
		.eff    (fm_eff),
		.word   (fm_word),
		.any    (fm_any)
	);

	// sequencer and page state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			dir_end_q   <= DE_W'(HEADER_BYTES);
			ras_q       <= OFF_W'(PAGE_BYTES);
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_GAP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					if (func_q == FUNC_INSERT ||
						(func_q == FUNC_UPDATE && !upd_inplace)) begin
						state_q <= ST_FIND;
					end else begin
						state_q <= ST_GAP;
					end
					if (func_q == FUNC_FORMAT) begin
						used_q    <= '0;
						dir_end_q <= DE_W'(HEADER_BYTES);
						ras_q     <= OFF_W'(PAGE_BYTES);
					end
				end
				ST_FIND: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					state_q <= no_new_slot ? ST_GAP : ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= alu_borrow ? ST_GAP : ST_PLACE;
				end
				ST_PLACE: begin
					ras_q <= alu_y[OFF_W-1:0];
					if (!found_q) begin
						used_q    <= used_q + 1'b1;
						dir_end_q <= dir_end_inc;
					end
					state_q <= ST_GAP;
				end
				ST_GAP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture, working values and result fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= func;
			slot_q <= slot_index;
			len_q  <= record_length;
		end
		case (state_q)
			ST_DECODE: begin
				case (func_q)
					FUNC_FORMAT: begin
						res_status_q <= ST_OK;
						res_slot_q   <= '0;
						res_off_q    <= OFF_W'(PAGE_BYTES);
						res_len_q    <= '0;
					end
					FUNC_LOOKUP: begin
						res_slot_q <= slot_q;
						if (in_range && ent_valid) begin
							res_status_q <= ST_OK;
							res_off_q    <= ent_off;
							res_len_q    <= ent_len;
						end else begin
							res_status_q <= ST_MISSING;
							res_off_q    <= '0;
							res_len_q    <= '0;
						end
					end
					FUNC_DELETE: begin
						res_status_q <= in_range ? ST_OK : ST_MISSING;
						res_slot_q   <= slot_q;
						res_off_q    <= '0;
						res_len_q    <= '0;
					end
					FUNC_UPDATE: begin
						// in-place values; a relocation overwrites them later
						res_status_q <= ST_OK;
						res_slot_q   <= slot_q;
						res_off_q    <= ent_off;
						res_len_q    <= OFF_W'(len_q);
					end
					FUNC_INSERT: begin
						res_status_q <= ST_OK;
						res_slot_q   <= '0;
						res_off_q    <= '0;
						res_len_q    <= '0;
					end
					default: begin
						res_status_q <= ST_MISSING;
						res_slot_q   <= '0;
						res_off_q    <= '0;
						res_len_q    <= '0;
					end
				endcase
			end
			ST_SCAN: begin
				found_q <= fm_any;
				bit_q   <= lowest_bit(fm_eff);
				reuse_q <= SLOT_W'({fm_word, lowest_bit(fm_eff)});
				acc_q   <= alu_y;
				if (no_new_slot) begin
					res_status_q <= ST_FULL;
					res_slot_q   <= '0;
					res_off_q    <= '0;
					res_len_q    <= '0;
				end
			end
			ST_CHECK: begin
				if (alu_borrow) begin
					res_status_q <= ST_FULL;
					res_slot_q   <= '0;
					res_off_q    <= '0;
					res_len_q    <= '0;
				end
			end
			ST_PLACE: begin
				res_status_q <= ST_OK;
				res_slot_q   <= found_q ? SLOT_IN_W'(reuse_q) : SLOT_IN_W'(used_q);
				res_off_q    <= alu_y[OFF_W-1:0];
				res_len_q    <= OFF_W'(len_q);
			end
			ST_GAP: begin
				if (out_free) begin
					status_q            <= res_status_q;
					slot_out_q          <= res_slot_q;
					rec_offset_q        <= LEN_IN_W'(res_off_q);
					record_length_out_q <= LEN_IN_W'(res_len_q);
					slot_count_q        <= COUNT_W'(used_q);
					free_gap_q          <= alu_borrow ? '0 : LEN_IN_W'(alu_y);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign slot_out          = slot_out_q;
	assign rec_offset        = rec_offset_q;
	assign record_length_out = record_length_out_q;
	assign slot_count        = slot_count_q;
	assign free_gap          = free_gap_q;

	// checks
	`SPM_ASSERT_IMPLY(a_used_le_max, clk, arst_n, 1'b1, used_q <= CNT_W'(MAX_SLOTS))
	`SPM_ASSERT_IMPLY(a_area_clear, clk, arst_n, 1'b1, AW'(ras_q) >= AW'(dir_end_q))
	`SPM_ASSERT_NEXT(a_accept_fetch, clk, arst_n, in_fire, state_q == ST_FETCH)
	`SPM_ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == ST_GAP && out_free, out_valid_q)

endmodule
`default_nettype wire

FILE: hw/rtl/spm_alu.sv
`default_nettype none
module spm_alu
	import spm_pkg::*;
#(
	parameter int AW = 16
) (
	input  logic          op,
	input  logic [AW-1:0] a,
	input  logic [AW-1:0] b,
	output logic [AW-1:0] y,
	output logic          borrow
);

	logic [AW:0] wide;

	// one adder/subtractor; borrow flags a < b on subtract
	always_comb begin
		if (op == ALU_SUB) begin
			wide = {1'b0, a} - {1'b0, b};
		end else begin
			wide = {1'b0, a} + {1'b0, b};
		end
	end

	assign y      = wide[AW-1:0];
	assign borrow = (op == ALU_SUB) && wide[AW];

endmodule
`default_nettype wire

FILE: hw/rtl/spm_dir_ram.sv
`default_nettype none
module spm_dir_ram
	import spm_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_SLOTS,
	parameter int AW    = 10,
	parameter int DW    = 27
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/spm_free_map.sv
`default_nettype none
module spm_free_map
	import spm_pkg::*;
#(
	parameter int NW   = 32,
	parameter int WI_W = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fm_ctrl_t        ctrl,
	input  logic [WI_W-1:0] rd_word,
	input  logic [WI_W-1:0] wr_word,
	input  logic [BM_W-1:0] wr_data,
	output logic [BM_W-1:0] eff,
	output logic [WI_W-1:0] word,
	output logic            any
);

	logic [BM_W-1:0] mem [NW];
	logic [NW-1:0]   summary_q;
	logic [WI_W-1:0] low_word;
	logic [WI_W-1:0] rd_addr;
	logic [BM_W-1:0] rd_q;
	logic            sel_q;
	logic [WI_W-1:0] word_q;
	logic            any_q;

	// lowest word that holds a deleted slot
	always_comb begin
		low_word = '0;
		for (int i = NW - 1; i >= 0; i--) begin
			if (summary_q[i]) begin
				low_word = WI_W'(i);
			end
		end
	end

	assign rd_addr = ctrl.rd_low ? low_word : rd_word;

	// bitmap words; a word whose summary bit is clear reads as all zero
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_word] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q   <= mem[rd_addr];
			sel_q  <= summary_q[rd_addr];
			word_q <= rd_addr;
			any_q  <= |summary_q;
		end
	end

	// one summary bit per word: any deleted slot in it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q <= '0;
		end else if (ctrl.clr_all) begin
			summary_q <= '0;
		end else if (ctrl.wr_en) begin
			summary_q[wr_word] <= |wr_data;
		end
	end

	assign eff  = sel_q ? rd_q : '0;
	assign word = word_q;
	assign any  = any_q;

endmodule
`default_nettype wire
